// ----- hw/rtl/rtc_alarm_match_table_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RTC_ALARM_MATCH_TABLE_ASSERT_SVH
`define RTC_ALARM_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held low.
`define RAMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define RAMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ramt_pkg.sv -----
package ramt_pkg;

    // Item kinds (input tuser)
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_STOP   = 3'd2;
    localparam logic [2:0] KIND_SET    = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // Alarm modes
    localparam logic [2:0] MODE_ONCE    = 3'd0;
    localparam logic [2:0] MODE_DAILY   = 3'd1;
    localparam logic [2:0] MODE_MONTHLY = 3'd2;
    localparam logic [2:0] MODE_YEARLY  = 3'd3;
    localparam logic [2:0] MODE_WEEKDAY = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_EXISTS = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // Defaults
    localparam int         DEF_ALARM_SLOTS = 16;
    localparam logic [4:0] DEF_MAX_ALARMS  = 5'd16;

    // Port widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;
    localparam int CFG_W     = 5;
    localparam int SLOT_IN_W = 4;
    localparam int COUNT_W   = 32;
    localparam int TIME_W    = 36;

    // Packed calendar time: sec, minute, hour, day, month, year, weekday from bit 0 up
    typedef logic [TIME_W-1:0] t_time;

    localparam t_time MASK_CLOCK = 36'h0_0001_FFFF;  // sec, minute, hour
    localparam t_time MASK_DAY   = 36'h0_003E_0000;
    localparam t_time MASK_MONTH = 36'h0_03C0_0000;
    localparam t_time MASK_YEAR  = 36'h1_FC00_0000;
    localparam t_time MASK_WDAY  = 36'hE_0000_0000;

    typedef struct packed {
        logic  bad;
        t_time mask;
    } t_mode_info;

    // Compare unit result for one slot
    typedef struct packed {
        logic hit;
        logic bad;
        logic once;
    } t_match;

    function automatic t_mode_info mode_info(input logic [2:0] mode);
        t_mode_info info;
        info.bad  = 1'b0;
        info.mask = '0;
        unique case (mode)
            MODE_ONCE:    info.mask = MASK_CLOCK | MASK_DAY | MASK_MONTH | MASK_YEAR;
            MODE_DAILY:   info.mask = MASK_CLOCK;
            MODE_MONTHLY: info.mask = MASK_CLOCK | MASK_DAY;
            MODE_YEARLY:  info.mask = MASK_CLOCK | MASK_DAY | MASK_MONTH;
            MODE_WEEKDAY: info.mask = MASK_CLOCK | MASK_WDAY;
            default:      info.bad  = 1'b1;
        endcase
        return info;
    endfunction

endpackage

// ----- hw/rtl/ramt_match.sv -----
// Shared masked compare: one stored alarm against the current time per cycle.
module ramt_match (
    input  ramt_pkg::t_time  i_slot_time,
    input  logic [2:0]       i_slot_mode,
    input  ramt_pkg::t_time  i_now,
    output ramt_pkg::t_match o_res
);
    import ramt_pkg::*;

    t_mode_info w_info;

    assign w_info = mode_info(i_slot_mode);

    // hit only for a known mode whose compared fields all agree
    assign o_res.bad  = w_info.bad;
    assign o_res.hit  = !w_info.bad && (((i_slot_time ^ i_now) & w_info.mask) == '0);
    assign o_res.once = (i_slot_mode == MODE_ONCE);

endmodule

// ----- hw/rtl/rtc_alarm_match_table.sv -----
// Channel   | Dir | Signals                         | Word
// ----------+-----+---------------------------------+-----------------------------------
// s_axis    | in  | tvalid tready tdata tuser       | command or tick, tuser = kind
// m_axis    | out | tvalid tready tdata tuser tlast | status/slot, tuser = fired
// cfg       | in  | valid ready data                | max_alarms, always ready
//
// Commands finish in their accept cycle; their result word sits in the output register the next cycle.
// A tick with a count not above the last sample finishes in its accept cycle.
// A scanning tick steps one shared compare unit over the slots, one slot per cycle from a
// registered table read while no output stall holds a waiting match, then flushes the held
// last match; s_axis is not ready meanwhile.
// Synchronous reset clears slot valid/enable bits at once; no clearing pass.
module rtc_alarm_match_table #(
    parameter int ALARM_SLOTS = ramt_pkg::DEF_ALARM_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // slot, mode, sec, minute, hour, day, month, year, weekday, second_count, zero pad
    input  logic [ramt_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // kind
    input  logic [ramt_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status, fired_slot, zero pad
    output logic [ramt_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // fired
    output logic [ramt_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ramt_pkg::CFG_W-1:0]     i_cfg_data
);
    import ramt_pkg::*;

    localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(ALARM_SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    // input word fields
    logic [2:0]           w_kind;
    logic [SLOT_IN_W-1:0] w_slot;
    logic [2:0]           w_mode;
    t_time                w_time;
    logic [COUNT_W-1:0]   w_count;
    logic [SLOT_W-1:0]    w_idx;
    logic                 w_inside;

    assign w_kind   = i_s_axis_tuser;
    assign w_slot   = i_s_axis_tdata[3:0];
    assign w_mode   = i_s_axis_tdata[6:4];
    assign w_time   = i_s_axis_tdata[42:7];
    assign w_count  = i_s_axis_tdata[74:43];
    assign w_idx    = SLOT_W'(w_slot);
    assign w_inside = (32'(w_slot) < 32'(ALARM_SLOTS));

    // control state
    logic [1:0]             r_state, n_state;
    logic [4:0]             r_max;
    logic [ALARM_SLOTS-1:0] r_valid, n_valid;
    logic [ALARM_SLOTS-1:0] r_enable, n_enable;
    logic [4:0]             r_created, n_created;
    logic [COUNT_W-1:0]     r_prev, n_prev;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic                   r_pend_vld, n_pend_vld;
    logic                   r_out_vld, n_out_vld;

    // payload
    t_time                r_now, n_now;
    logic [SLOT_IN_W-1:0] r_pend_slot, n_pend_slot;
    logic [1:0]           r_out_status, n_out_status;
    logic                 r_out_fired, n_out_fired;
    logic [SLOT_IN_W-1:0] r_out_slot, n_out_slot;
    logic                 r_out_last, n_out_last;

    // slot table memories
    logic [2:0] mem_mode [ALARM_SLOTS];
    t_time      mem_time [ALARM_SLOTS];
    logic [2:0] r_rd_mode;
    t_time      r_rd_time;
    logic       w_we_mode, w_we_time;

    t_match w_res;
    logic   w_accept, w_out_free, w_active, w_stall;

    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out_slot, r_out_status};
    assign o_m_axis_tuser  = r_out_fired;
    assign o_m_axis_tlast  = r_out_last;

    ramt_match u_match (
        .i_slot_time (r_rd_time),
        .i_slot_mode (r_rd_mode),
        .i_now       (r_now),
        .o_res       (w_res)
    );

    // slot under the compare unit; a match needs the pending word moved out first
    assign w_active = r_valid[r_idx] && r_enable[r_idx];
    assign w_stall  = w_active && w_res.hit && r_pend_vld && !w_out_free;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_enable     = r_enable;
        n_created    = r_created;
        n_prev       = r_prev;
        n_idx        = r_idx;
        n_pend_vld   = r_pend_vld;
        n_pend_slot  = r_pend_slot;
        n_now        = r_now;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_fired  = r_out_fired;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        w_we_mode    = 1'b0;
        w_we_time    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    unique case (w_kind)
                        KIND_CREATE: begin
                            n_out_vld   = 1'b1;
                            n_out_fired = 1'b0;
                            n_out_slot  = '0;
                            n_out_last  = 1'b1;
                            if (r_created >= r_max) begin
                                n_out_status = ST_LIMIT;
                            end else if (!w_inside) begin
                                n_out_status = ST_ABSENT;
                            end else if (r_valid[w_idx]) begin
                                n_out_status = ST_EXISTS;
                            end else begin
                                n_out_status     = ST_OK;
                                n_valid[w_idx]   = 1'b1;
                                n_enable[w_idx]  = 1'b0;
                                n_created        = r_created + 5'd1;
                                w_we_mode        = 1'b1;
                                w_we_time        = 1'b1;
                            end
                        end
                        KIND_START, KIND_STOP, KIND_SET: begin
                            n_out_vld   = 1'b1;
                            n_out_fired = 1'b0;
                            n_out_slot  = '0;
                            n_out_last  = 1'b1;
                            if (!w_inside || !r_valid[w_idx]) begin
                                n_out_status = ST_ABSENT;
                            end else begin
                                n_out_status    = ST_OK;
                                n_enable[w_idx] = (w_kind != KIND_STOP);
                                w_we_time       = (w_kind == KIND_SET);
                            end
                        end
                        KIND_TICK: begin
                            n_prev = w_count;
                            if (r_prev < w_count) begin
                                n_now   = w_time;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_stall) begin
                    if (w_active && w_res.bad) begin
                        n_enable[r_idx] = 1'b0;
                    end
                    if (w_active && w_res.hit) begin
                        if (r_pend_vld) begin
                            n_out_vld    = 1'b1;
                            n_out_status = ST_OK;
                            n_out_fired  = 1'b1;
                            n_out_slot   = r_pend_slot;
                            n_out_last   = 1'b0;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = SLOT_IN_W'(r_idx);
                        if (w_res.once) begin
                            n_enable[r_idx] = 1'b0;
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_fired  = 1'b1;
                    n_out_slot   = r_pend_slot;
                    n_out_last   = 1'b1;
                    n_pend_vld   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max      <= DEF_MAX_ALARMS;
            r_valid    <= '0;
            r_enable   <= '0;
            r_created  <= '0;
            r_prev     <= '0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_enable   <= n_enable;
            r_created  <= n_created;
            r_prev     <= n_prev;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_pend_slot  <= n_pend_slot;
        r_out_status <= n_out_status;
        r_out_fired  <= n_out_fired;
        r_out_slot   <= n_out_slot;
        r_out_last   <= n_out_last;
    end

    // slot table: one write port, registered read at the next scan index
    always_ff @(posedge i_clk) begin
        if (w_we_mode) begin
            mem_mode[w_idx] <= w_mode;
        end
        if (w_we_time) begin
            mem_time[w_idx] <= w_time;
        end
        r_rd_mode <= mem_mode[n_idx];
        r_rd_time <= mem_time[n_idx];
    end

endmodule

// ----- hw/rtl/ramt_check.sv -----
`include "rtc_alarm_match_table_assert.svh"

// Port-level checks for the alarm table.
module ramt_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [ramt_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [ramt_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    input logic                           o_m_axis_tlast
);
    import ramt_pkg::*;

    logic                         w_held;
    logic                         w_cmd_out;
    logic                         w_fired_out;
    logic [M_TDATA_W+M_TUSER_W:0] w_out_word;

    // result word as seen on the port, and its qualifiers
    assign w_held      = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_cmd_out   = o_m_axis_tvalid && !o_m_axis_tuser[0];
    assign w_fired_out = o_m_axis_tvalid && o_m_axis_tuser[0];
    assign w_out_word  = {o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};

    // stalled result word holds
    `RAMT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_held,
        o_m_axis_tvalid && $stable(w_out_word), "result word changed while stalled")

    // command results are single words with no slot
    `RAMT_ASSERT_IMP(a_cmd_word, i_clk, i_rst_n, w_cmd_out,
        o_m_axis_tlast && (o_m_axis_tdata[5:2] == 4'd0), "command result not a lone word")

    // match results always report ok
    `RAMT_ASSERT_IMP(a_fired_ok, i_clk, i_rst_n, w_fired_out,
        o_m_axis_tdata[1:0] == ST_OK, "fired result with error status")

    // no new word is taken while a result is stuck
    `RAMT_ASSERT_IMP(a_no_take, i_clk, i_rst_n, w_held,
        !o_s_axis_tready, "input taken while output stalled")

endmodule

bind rtc_alarm_match_table ramt_check u_ramt_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
